### rtl/plru_pkg.sv
// Shared types, codes and constants for the tree pseudo-LRU replacement block.
package plru_pkg;

   // Widths of the request and response fields.
   localparam int REQ_W = 2;
   localparam int SET_W = 6;
   localparam int WAY_W = 3;

   // Default geometry of the cache that the block serves.
   localparam int DEF_SETS = 64;
   localparam int DEF_WAYS = 8;

   // Request codes carried on req_type.
   localparam logic [REQ_W-1:0] REQ_VICTIM = 2'd0;
   localparam logic [REQ_W-1:0] REQ_FILL   = 2'd1;
   localparam logic [REQ_W-1:0] REQ_ACCESS = 2'd2;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } plru_state_type;

   // Control group passed from the sequencer to the datapath.
   typedef struct packed {
      logic busy;
      logic accept;
      logic clearing;
      logic exec;
   } plru_ctl_type;

endpackage

### rtl/plru_mem.sv
// Tree-bit store: one word per set, one write port and one registered read port.
module plru_mem #(
   parameter int SETS = plru_pkg::DEF_SETS,
   parameter int AW   = 6,
   parameter int DW   = 7
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data
);
   import plru_pkg::*;

   logic [DW-1:0] tree_mem [SETS];
   logic [DW-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         tree_mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= tree_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/plru_tree.sv
// Tree walk logic: victim selection and path update for one set's tree bits.
module plru_tree #(
   parameter int WAYS = plru_pkg::DEF_WAYS
) (
   input  logic [WAYS-2:0]            bits_in,
   input  logic [plru_pkg::WAY_W-1:0] way,
   output logic [plru_pkg::WAY_W-1:0] victim_way,
   output logic [WAYS-2:0]            bits_out
);
   import plru_pkg::*;

   // Tree depth, node index width and the width used to range-check the way.
   localparam int L  = $clog2(WAYS);
   localparam int NW = (WAYS > 2) ? $clog2(WAYS - 1) : 1;
   localparam int EW = (L > WAY_W) ? L : WAY_W;

   logic [L-1:0]  vpath;
   logic [NW-1:0] v_node;
   logic [EW-1:0] way_ext;
   logic [L-1:0]  tpath;
   logic [NW-1:0] t_node;

   // Victim walk: each level's bit picks the next half, and the bits read
   // along the way spell out the victim, most significant first.
   always_comb begin
      vpath  = '0;
      v_node = '0;
      for (int k = 0; k < L; k++) begin
         v_node = NW'((1 << k) - 1) + NW'(vpath >> (L - k));
         vpath[L-1-k] = bits_in[v_node];
      end
   end

   assign victim_way = WAY_W'({{WAY_W{1'b0}}, vpath});

   // A way beyond the last one always walks right, so it lands on the last way.
   assign way_ext = EW'(way);
   assign tpath   = (way_ext > EW'(WAYS - 1)) ? L'(WAYS - 1) : L'(way_ext);

   // Touch: every node on the path is set to point away from the way.
   always_comb begin
      bits_out = bits_in;
      t_node   = '0;
      for (int k = 0; k < L; k++) begin
         t_node = NW'((1 << k) - 1) + NW'(tpath >> (L - k));
         bits_out[t_node] = ~tpath[L-1-k];
      end
   end

endmodule

### rtl/plru_ctrl.sv
// Sequencer: clearing pass after reset, then one read and one write-back per beat.
module plru_ctrl #(
   parameter int SETS = plru_pkg::DEF_SETS,
   parameter int AW   = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output plru_pkg::plru_ctl_type ctl,
   output logic [AW-1:0]          clear_addr
);
   import plru_pkg::*;

   plru_state_type state_ff, state_in;
   logic [AW-1:0]  clr_cnt_ff, clr_cnt_in;

   // State and clearing counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // Next state and control outputs.
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      ctl        = '0;
      case (state_ff)
         ST_CLEAR: begin
            ctl.busy     = 1'b1;
            ctl.clearing = 1'b1;
            if (clr_cnt_ff == AW'(SETS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_cnt_in = AW'(clr_cnt_ff + 1'b1);
            end
         end
         ST_IDLE: begin
            if (start) begin
               ctl.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ctl.busy = 1'b1;
            ctl.exec = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign clear_addr = clr_cnt_ff;

endmodule

### rtl/tree_plru_replacement.sv
// Top level of the tree pseudo-LRU replacement block for a set-associative cache.
//
//   Channel   Ports                                            Direction
//   request   start, busy, req_type, req_set_index, req_way,  in
//             req_hit, req_is_write
//   response  rsp_valid, rsp_victim_way                        out
//
// Each request reads the set's tree word from the memory in the accept cycle
// and, for a fill or a read hit, modifies it and writes it back in the next,
// which is held busy. A victim query's answer shows on the response ports for one cycle
// after that. After reset a clearing pass zeroes the memory word by word,
// with busy high. The receiver cannot stall responses.
module tree_plru_replacement #(
   parameter int SETS = plru_pkg::DEF_SETS,
   parameter int WAYS = plru_pkg::DEF_WAYS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [plru_pkg::REQ_W-1:0]  req_type,
   input  logic [plru_pkg::SET_W-1:0]  req_set_index,
   input  logic [plru_pkg::WAY_W-1:0]  req_way,
   input  logic                        req_hit,
   input  logic                        req_is_write,
   output logic                        rsp_valid,
   output logic [plru_pkg::WAY_W-1:0]  rsp_victim_way
);
   import plru_pkg::*;

   localparam int AW = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int TW = WAYS - 1;

   plru_ctl_type  ctl;
   logic [AW-1:0] clear_addr;

   logic          in_range;
   logic          touch;
   logic [AW-1:0] req_addr;

   logic          query_ff, touch_ff, in_range_ff;
   logic [AW-1:0] addr_ff;
   logic [WAY_W-1:0] way_ff;

   logic [TW-1:0]    rd_bits;
   logic [TW-1:0]    new_bits;
   logic [WAY_W-1:0] victim;

   logic             mem_wr_en;
   logic [AW-1:0]    mem_wr_addr;
   logic [TW-1:0]    mem_wr_data;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [WAY_W-1:0] rsp_victim_ff, rsp_victim_in;

   // Sequencer.
   plru_ctrl #(
      .SETS (SETS),
      .AW   (AW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .ctl        (ctl),
      .clear_addr (clear_addr)
   );

   assign busy = ctl.busy;

   // Decode of the request beat.
   assign in_range = 32'(req_set_index) < 32'(SETS);
   assign req_addr = AW'(req_set_index);
   assign touch    = in_range && ((req_type == REQ_FILL) ||
                     ((req_type == REQ_ACCESS) && req_hit && !req_is_write));

   // Request registers held through the write-back cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         query_ff    <= 1'b0;
         touch_ff    <= 1'b0;
         in_range_ff <= 1'b0;
      end else if (ctl.accept) begin
         query_ff    <= (req_type == REQ_VICTIM);
         touch_ff    <= touch;
         in_range_ff <= in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         addr_ff <= req_addr;
         way_ff  <= req_way;
      end
   end

   // Tree-bit memory: cleared word by word after reset, then read on accept and,
   // on a fill or a read hit, written back in the following cycle.
   assign mem_wr_en   = ctl.clearing || (ctl.exec && touch_ff);
   assign mem_wr_addr = ctl.clearing ? clear_addr : addr_ff;
   assign mem_wr_data = ctl.clearing ? '0 : new_bits;

   plru_mem #(
      .SETS (SETS),
      .AW   (AW),
      .DW   (TW)
   ) u_mem (
      .clock   (clock),
      .rd_en   (ctl.accept),
      .rd_addr (req_addr),
      .rd_data (rd_bits),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   // Victim walk and path update on the word just read.
   plru_tree #(
      .WAYS (WAYS)
   ) u_tree (
      .bits_in    (rd_bits),
      .way        (way_ff),
      .victim_way (victim),
      .bits_out   (new_bits)
   );

   // Response register: a query out of range answers way zero.
   assign rsp_valid_in  = ctl.exec && query_ff;
   assign rsp_victim_in = in_range_ff ? victim : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_in) begin
         rsp_victim_ff <= rsp_victim_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_victim_way = rsp_victim_ff;

   // An accepted beat always holds the block busy for its write-back cycle.
   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.accept |=> (busy && ctl.exec))
      else $error("write-back cycle missing after an accepted beat");

   // A response only appears in the cycle after a write-back cycle.
   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(ctl.exec) && !busy))
      else $error("response strobe without a preceding write-back cycle");

   // The memory is only written while clearing or in a write-back cycle.
   a_write_when_busy: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (ctl.clearing || ctl.exec))
      else $error("tree memory written outside clearing or write-back");

   // No request is taken while the clearing pass runs.
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      ctl.clearing |-> !ctl.accept)
      else $error("request accepted during the clearing pass");

endmodule

### tb/sv/plru_checker.sv
// Checker for the tree pseudo-LRU block: predicts victim answers and compares each response beat.
`timescale 1ns / 100ps

module plru_checker #(
   parameter int SETS = plru_pkg::DEF_SETS,
   parameter int WAYS = plru_pkg::DEF_WAYS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic [plru_pkg::REQ_W-1:0]  req_type,
   input  logic [plru_pkg::SET_W-1:0]  req_set_index,
   input  logic [plru_pkg::WAY_W-1:0]  req_way,
   input  logic                        req_hit,
   input  logic                        req_is_write,
   input  logic                        rsp_valid,
   input  logic [plru_pkg::WAY_W-1:0]  rsp_victim_way,
   output int                          mismatches,
   output int                          outstanding
);
   import plru_pkg::*;

   localparam int TREE_W = WAYS - 1;

   // Predicted tree bits per set, and the victim answers still awaited.
   logic [TREE_W-1:0] pred_tree [SETS];
   logic [WAY_W-1:0]  victim_q [$];
   logic [WAY_W-1:0]  expected_way;

   // Walk from the root: a clear bit sends the walk left, a set bit right.
   function automatic logic [WAY_W-1:0] walk_to_victim(input logic [TREE_W-1:0] tree);
      int node;
      int lo;
      int hi;
      int mid;
      node = 0;
      lo = 0;
      hi = WAYS - 1;
      while (lo != hi) begin
         mid = (lo + hi) / 2;
         if (!tree[node]) begin
            node = 2 * node + 1;
            hi = mid;
         end else begin
            node = 2 * node + 2;
            lo = mid + 1;
         end
      end
      return lo[WAY_W-1:0];
   endfunction

   // Point every node on the path to the given way away from it.
   function automatic logic [TREE_W-1:0] touch_path(input logic [TREE_W-1:0] tree,
                                                    input logic [WAY_W-1:0] w);
      int node;
      int lo;
      int hi;
      int mid;
      node = 0;
      lo = 0;
      hi = WAYS - 1;
      while (lo != hi) begin
         mid = (lo + hi) / 2;
         if (int'(w) <= mid) begin
            tree[node] = 1'b1;
            node = 2 * node + 1;
            hi = mid;
         end else begin
            tree[node] = 1'b0;
            node = 2 * node + 2;
            lo = mid + 1;
         end
      end
      return tree;
   endfunction

   function automatic void report_mismatch(input string what, input int exp_val,
                                           input int act_val);
      mismatches++;
      if (mismatches <= 10) begin
         $display("plru_checker: %s at %0t: expected %0d, got %0d",
                  what, $realtime, exp_val, act_val);
      end
   endfunction

   initial begin
      mismatches = 0;
      outstanding = 0;
      for (int s = 0; s < SETS; s++) begin
         pred_tree[s] = '0;
      end
   end

   // Response beats are matched first, since any answer on the port now belongs
   // to a query accepted at an earlier edge; then the request beat is predicted.
   always @(posedge clock) begin
      if (reset) begin
         victim_q.delete();
         for (int s = 0; s < SETS; s++) begin
            pred_tree[s] = '0;
         end
      end else begin
         if (rsp_valid) begin
            if (victim_q.size() == 0) begin
               report_mismatch("victim answer with no query pending", -1,
                               int'(rsp_victim_way));
            end else begin
               expected_way = victim_q.pop_front();
               if (rsp_victim_way !== expected_way) begin
                  report_mismatch("victim_way", int'(expected_way), int'(rsp_victim_way));
               end
            end
         end
         if (start && !busy) begin
            case (req_type)
               REQ_VICTIM: begin
                  victim_q.push_back(walk_to_victim(pred_tree[req_set_index]));
               end
               REQ_FILL: begin
                  pred_tree[req_set_index] = touch_path(pred_tree[req_set_index], req_way);
               end
               REQ_ACCESS: begin
                  // Only a read hit refreshes the tree.
                  if (req_hit && !req_is_write) begin
                     pred_tree[req_set_index] = touch_path(pred_tree[req_set_index],
                                                           req_way);
                  end
               end
               default: begin
               end
            endcase
         end
      end
      outstanding = victim_q.size();
   end

endmodule

### tb/sv/tb.sv
// Testbench top for the tree pseudo-LRU block: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module tb;
   import plru_pkg::*;

   // The fourth request code is unused by the block.
   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
   localparam int LIMIT_CYCLES = 100000;
   localparam int PHASE_BEATS  = 300;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [REQ_W-1:0]  req_type;
   logic [SET_W-1:0]  req_set_index;
   logic [WAY_W-1:0]  req_way;
   logic              req_hit;
   logic              req_is_write;
   logic              rsp_valid;
   logic [WAY_W-1:0]  rsp_victim_way;
   int                mismatches;
   int                outstanding;
   int                cycle_count;

   tree_plru_replacement dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_set_index  (req_set_index),
      .req_way        (req_way),
      .req_hit        (req_hit),
      .req_is_write   (req_is_write),
      .rsp_valid      (rsp_valid),
      .rsp_victim_way (rsp_victim_way)
   );

   plru_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_set_index  (req_set_index),
      .req_way        (req_way),
      .req_hit        (req_hit),
      .req_is_write   (req_is_write),
      .rsp_valid      (rsp_valid),
      .rsp_victim_way (rsp_victim_way),
      .mismatches     (mismatches),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: a run that hangs is a failure.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Present one request beat and hold it until the block takes it. Called at a
   // falling edge; busy only moves at rising edges, so once it reads low at a
   // falling edge the next rising edge accepts the beat.
   task automatic issue(input logic [REQ_W-1:0] kind, input logic [SET_W-1:0] set_sel,
                        input logic [WAY_W-1:0] way_sel, input logic hit_flag,
                        input logic wr_flag);
      start         <= 1'b1;
      req_type      <= kind;
      req_set_index <= set_sel;
      req_way       <= way_sel;
      req_hit       <= hit_flag;
      req_is_write  <= wr_flag;
      while (busy) begin
         @(negedge clock);
      end
      @(negedge clock);
   endtask

   // Random sender gap, taken in idle_pct beats out of a hundred.
   task automatic sender_gap(input int idle_pct);
      if ($urandom_range(99, 0) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
   endtask

   // Hold off until every victim answer predicted so far has arrived.
   task automatic drain_answers();
      start <= 1'b0;
      do begin
         @(negedge clock);
      end while (outstanding != 0);
   endtask

   // Random traffic, mostly on a few hot sets so that the trees get deep
   // histories; only beats that query or change a tree count as useful.
   task automatic random_phase(input int useful_beats, input int idle_pct);
      int                useful;
      int                pick;
      logic [SET_W-1:0]  set_sel;
      logic [REQ_W-1:0]  kind;
      logic              hit_flag;
      logic              wr_flag;
      useful = 0;
      while (useful < useful_beats) begin
         pick = $urandom_range(99, 0);
         if (pick < 80) begin
            set_sel = SET_W'($urandom_range(7, 0));
         end else if (pick < 90) begin
            set_sel = SET_W'($urandom_range(63, 56));
         end else begin
            set_sel = SET_W'($urandom_range(63, 0));
         end
         hit_flag = ($urandom_range(99, 0) < 80);
         wr_flag  = ($urandom_range(99, 0) < 25);
         pick = $urandom_range(99, 0);
         if (pick < 35) begin
            kind = REQ_VICTIM;
         end else if (pick < 65) begin
            kind = REQ_FILL;
         end else if (pick < 95) begin
            kind = REQ_ACCESS;
         end else begin
            kind = REQ_UNUSED;
         end
         sender_gap(idle_pct);
         issue(kind, set_sel, WAY_W'($urandom_range(7, 0)), hit_flag, wr_flag);
         if (kind == REQ_VICTIM || kind == REQ_FILL ||
             (kind == REQ_ACCESS && hit_flag && !wr_flag)) begin
            useful++;
         end
      end
   endtask

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_type      = REQ_VICTIM;
      req_set_index = '0;
      req_way       = '0;
      req_hit       = 1'b0;
      req_is_write  = 1'b0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: fresh trees, every way filled in turn, each kind of access
      // update, the unused request code and the highest set.
      issue(REQ_VICTIM, 6'd0, 3'd0, 1'b0, 1'b0);
      issue(REQ_VICTIM, 6'd63, 3'd7, 1'b1, 1'b1);
      for (int w = 0; w < 8; w++) begin
         issue(REQ_FILL, 6'd1, WAY_W'(w), 1'b0, 1'b0);
         issue(REQ_VICTIM, 6'd1, 3'd0, 1'b0, 1'b0);
      end
      issue(REQ_ACCESS, 6'd1, 3'd0, 1'b1, 1'b0);
      issue(REQ_VICTIM, 6'd1, 3'd0, 1'b0, 1'b0);
      issue(REQ_ACCESS, 6'd1, 3'd4, 1'b1, 1'b1);
      issue(REQ_ACCESS, 6'd1, 3'd6, 1'b0, 1'b0);
      issue(REQ_UNUSED, 6'd1, 3'd2, 1'b1, 1'b0);
      issue(REQ_VICTIM, 6'd1, 3'd0, 1'b0, 1'b0);
      issue(REQ_FILL, 6'd63, 3'd7, 1'b1, 1'b1);
      issue(REQ_VICTIM, 6'd63, 3'd0, 1'b0, 1'b0);
      drain_answers();

      // Random part in phases of sender pressure, waiting for all answers
      // between phases.
      random_phase(PHASE_BEATS, 0);
      drain_answers();
      random_phase(PHASE_BEATS, 77);
      drain_answers();
      random_phase(PHASE_BEATS, 0);
      drain_answers();
      random_phase(PHASE_BEATS, 29);

      // Let the last answers come, then wait on for any stray beat.
      drain_answers();
      repeat (8) @(negedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
